// ===== rtl/core/rte_pkg.sv =====
// ----------------------------------------------------------------------------
// rte_pkg
// Types, constants and the step program of the two-parameter rls estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package rte_pkg;

    localparam int unsigned VAL_W     = 56;
    localparam int unsigned SMP_W     = 32;
    localparam int unsigned COV_W     = 55;
    localparam int unsigned ACC_W     = 114;
    localparam int unsigned HALF_W    = 28;
    localparam int unsigned DIV_STEPS = 84;
    localparam int unsigned DCNT_W    = 7;
    localparam int unsigned PC_W      = 6;
    localparam int unsigned PROG_LEN  = 33;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [PC_W-1:0]  PC_LAST       = PC_W'(PROG_LEN - 1);
    localparam logic [COV_W-1:0] INIT_COV_RST  = 55'd2415919104000000;
    localparam logic             REQ_RESTART   = 1'b1;
    localparam logic             MODE_FIRST    = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE,
        CFG_DECAY_FIRST,
        CFG_GAIN_FIRST,
        CFG_DECAY_SECOND,
        CFG_GAIN_SECOND_CUR,
        CFG_GAIN_SECOND_VOLT,
        CFG_INIT_COV
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OPD_PHI0, OPD_PHI1,
        OPD_C0, OPD_C1, OPD_C2, OPD_C3,
        OPD_T0, OPD_T1, OPD_DEN,
        OPD_G0, OPD_G1,
        OPD_PAR0, OPD_PAR1,
        OPD_PRED, OPD_ERR,
        OPD_ONE, OPD_UNIT, OPD_Y12,
        OPD_DECAY, OPD_GAIN0, OPD_GAIN1, OPD_DIFF0, OPD_DIFF1
    } t_opd;

    typedef enum logic [1:0] {SH_0, SH_28, SH_30} t_shift;
    typedef enum logic {K_MAC, K_DIV} t_kind;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MAC_WAIT, S_FIN, S_DIV_WAIT, S_OUT
    } t_state;

    typedef struct packed {
        t_kind  kind;
        t_opd   a;
        t_opd   b;
        logic   neg;
        logic   last;
        t_shift sh;
        t_opd   dst;
    } t_uop;

    typedef struct packed {
        logic load;
        logic restart;
        logic mac_start;
        logic mac_clear;
        logic fin_write;
        logic div_start;
        logic div_write;
        logic zero_write;
        logic out_write;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic mac_done;
        logic div_done;
        logic den_pos;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic                    req_type;
        logic signed [SMP_W-1:0] voltage_sample;
        logic signed [SMP_W-1:0] current_sample;
        logic signed [SMP_W-1:0] measured_output;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] predicted_output;
        logic signed [VAL_W-1:0] param_first;
        logic signed [VAL_W-1:0] param_second;
        logic                    saturated;
    } t_out_item;

    function automatic t_uop mk(input t_kind k, input t_opd a, input t_opd b,
                                input logic ng, input logic ls, input t_shift sh,
                                input t_opd d);
        t_uop u;
        u.kind = k;
        u.a    = a;
        u.b    = b;
        u.neg  = ng;
        u.last = ls;
        u.sh   = sh;
        u.dst  = d;
        return u;
    endfunction

    function automatic t_uop prog(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk(K_MAC, OPD_DECAY, OPD_PHI0,  1'b0, 1'b0, SH_30, OPD_PHI0);
            6'd1:  u = mk(K_MAC, OPD_GAIN0, OPD_DIFF0, 1'b0, 1'b1, SH_30, OPD_PHI0);
            6'd2:  u = mk(K_MAC, OPD_DECAY, OPD_PHI1,  1'b0, 1'b0, SH_30, OPD_PHI1);
            6'd3:  u = mk(K_MAC, OPD_GAIN1, OPD_DIFF1, 1'b0, 1'b1, SH_30, OPD_PHI1);
            6'd4:  u = mk(K_MAC, OPD_PHI0,  OPD_C0,    1'b0, 1'b0, SH_28, OPD_T0);
            6'd5:  u = mk(K_MAC, OPD_PHI1,  OPD_C1,    1'b0, 1'b1, SH_28, OPD_T0);
            6'd6:  u = mk(K_MAC, OPD_PHI0,  OPD_C2,    1'b0, 1'b0, SH_28, OPD_T1);
            6'd7:  u = mk(K_MAC, OPD_PHI1,  OPD_C3,    1'b0, 1'b1, SH_28, OPD_T1);
            6'd8:  u = mk(K_MAC, OPD_PHI0,  OPD_T0,    1'b0, 1'b0, SH_28, OPD_DEN);
            6'd9:  u = mk(K_MAC, OPD_PHI1,  OPD_T1,    1'b0, 1'b0, SH_28, OPD_DEN);
            6'd10: u = mk(K_MAC, OPD_ONE,   OPD_ONE,   1'b0, 1'b1, SH_28, OPD_DEN);
            6'd11: u = mk(K_DIV, OPD_T0,    OPD_DEN,   1'b0, 1'b0, SH_0,  OPD_G0);
            6'd12: u = mk(K_DIV, OPD_T1,    OPD_DEN,   1'b0, 1'b0, SH_0,  OPD_G1);
            6'd13: u = mk(K_MAC, OPD_PHI0,  OPD_C0,    1'b0, 1'b0, SH_28, OPD_T0);
            6'd14: u = mk(K_MAC, OPD_PHI1,  OPD_C2,    1'b0, 1'b1, SH_28, OPD_T0);
            6'd15: u = mk(K_MAC, OPD_PHI0,  OPD_C1,    1'b0, 1'b0, SH_28, OPD_T1);
            6'd16: u = mk(K_MAC, OPD_PHI1,  OPD_C3,    1'b0, 1'b1, SH_28, OPD_T1);
            6'd17: u = mk(K_MAC, OPD_ONE,   OPD_C0,    1'b0, 1'b0, SH_28, OPD_C0);
            6'd18: u = mk(K_MAC, OPD_T0,    OPD_G0,    1'b1, 1'b1, SH_28, OPD_C0);
            6'd19: u = mk(K_MAC, OPD_ONE,   OPD_C1,    1'b0, 1'b0, SH_28, OPD_C1);
            6'd20: u = mk(K_MAC, OPD_T1,    OPD_G0,    1'b1, 1'b1, SH_28, OPD_C1);
            6'd21: u = mk(K_MAC, OPD_ONE,   OPD_C2,    1'b0, 1'b0, SH_28, OPD_C2);
            6'd22: u = mk(K_MAC, OPD_T0,    OPD_G1,    1'b1, 1'b1, SH_28, OPD_C2);
            6'd23: u = mk(K_MAC, OPD_ONE,   OPD_C3,    1'b0, 1'b0, SH_28, OPD_C3);
            6'd24: u = mk(K_MAC, OPD_T1,    OPD_G1,    1'b1, 1'b1, SH_28, OPD_C3);
            6'd25: u = mk(K_MAC, OPD_PHI0,  OPD_PAR0,  1'b0, 1'b0, SH_28, OPD_PRED);
            6'd26: u = mk(K_MAC, OPD_PHI1,  OPD_PAR1,  1'b0, 1'b1, SH_28, OPD_PRED);
            6'd27: u = mk(K_MAC, OPD_Y12,   OPD_UNIT,  1'b0, 1'b0, SH_0,  OPD_ERR);
            6'd28: u = mk(K_MAC, OPD_PRED,  OPD_UNIT,  1'b1, 1'b1, SH_0,  OPD_ERR);
            6'd29: u = mk(K_MAC, OPD_ONE,   OPD_PAR0,  1'b0, 1'b0, SH_28, OPD_PAR0);
            6'd30: u = mk(K_MAC, OPD_G0,    OPD_ERR,   1'b0, 1'b1, SH_28, OPD_PAR0);
            6'd31: u = mk(K_MAC, OPD_ONE,   OPD_PAR1,  1'b0, 1'b0, SH_28, OPD_PAR1);
            6'd32: u = mk(K_MAC, OPD_G1,    OPD_ERR,   1'b0, 1'b1, SH_28, OPD_PAR1);
            default: u = mk(K_MAC, OPD_ONE, OPD_ONE,  1'b0, 1'b1, SH_28, OPD_PAR1);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rte_mac.sv =====
// ----------------------------------------------------------------------------
// rte_mac
// Signed 56x56 multiply-accumulate from four 28x28 partial products, with
// rounding and saturation of the sum to Q28.28.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_mac (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic                             i_clear,
    input  wire logic signed [rte_pkg::VAL_W-1:0] i_a,
    input  wire logic signed [rte_pkg::VAL_W-1:0] i_b,
    input  wire logic                             i_neg,
    input  wire rte_pkg::t_shift                  i_sh,
    output logic                                  o_done,
    output logic signed [rte_pkg::VAL_W-1:0]      o_res,
    output logic                                  o_ovf
);

    localparam int unsigned VW = rte_pkg::VAL_W;
    localparam int unsigned HW = rte_pkg::HALF_W;
    localparam int unsigned AW = rte_pkg::ACC_W;

    logic [VW-1:0]         r_ma, r_mb, a_mag, b_mag;
    logic                  r_sg, r_busy, r_pv;
    logic [2:0]            r_cnt;
    logic [2*HW-1:0]       r_pp;
    logic [1:0]            r_pw;
    logic signed [AW-1:0]  r_acc;
    logic [HW-1:0]         a_part, b_part;
    logic [AW-1:0]         pp_wide;
    logic signed [AW-1:0]  term, rnd;
    logic [AW-VW:0]        hi_bits;

    assign a_mag  = i_a[VW-1] ? VW'(-i_a) : VW'(i_a);
    assign b_mag  = i_b[VW-1] ? VW'(-i_b) : VW'(i_b);
    assign a_part = r_cnt[1] ? r_ma[VW-1:HW] : r_ma[HW-1:0];
    assign b_part = r_cnt[0] ? r_mb[VW-1:HW] : r_mb[HW-1:0];

    always_comb begin
        case (r_pw)
            2'd0:    pp_wide = AW'(r_pp);
            2'd1:    pp_wide = AW'(r_pp) << HW;
            default: pp_wide = AW'(r_pp) << (2 * HW);
        endcase
        term = r_sg ? -$signed(pp_wide) : $signed(pp_wide);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_cnt  <= '0;
            r_acc  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_pv   <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_pv  <= 1'b1;
                    r_cnt <= r_cnt + 3'd1;
                end else begin
                    r_pv   <= 1'b0;
                    r_busy <= 1'b0;
                end
            end
            if (i_clear) begin
                r_acc <= '0;
            end else if (r_pv) begin
                r_acc <= r_acc + term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma <= a_mag;
            r_mb <= b_mag;
            r_sg <= i_a[VW-1] ^ i_b[VW-1] ^ i_neg;
        end
        if (r_busy && r_cnt != 3'd4) begin
            r_pp <= a_part * b_part;
            r_pw <= 2'(r_cnt[1]) + 2'(r_cnt[0]);
        end
    end

    assign o_done = r_busy && r_cnt == 3'd4;

    always_comb begin
        case (i_sh)
            rte_pkg::SH_28: rnd = (r_acc + (AW'(1) << 27)) >>> 28;
            rte_pkg::SH_30: rnd = (r_acc + (AW'(1) << 29)) >>> 30;
            default:        rnd = r_acc;
        endcase
        hi_bits = rnd[AW-1:VW-1];
        o_ovf   = !((&hi_bits) || !(|hi_bits));
        if (!o_ovf) begin
            o_res = rnd[VW-1:0];
        end else if (rnd[AW-1]) begin
            o_res = {1'b1, {(VW-1){1'b0}}};
        end else begin
            o_res = {1'b0, {(VW-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rte_div.sv =====
// ----------------------------------------------------------------------------
// rte_div
// Radix-2 restoring divider: (t << 28) / den, rounded to nearest with ties
// away from zero, saturated to Q28.28.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic signed [rte_pkg::VAL_W-1:0] i_num,
    input  wire logic signed [rte_pkg::VAL_W-1:0] i_den,
    output logic                                  o_done,
    output logic signed [rte_pkg::VAL_W-1:0]      o_res,
    output logic                                  o_ovf
);

    localparam int unsigned VW = rte_pkg::VAL_W;
    localparam int unsigned QW = rte_pkg::DIV_STEPS;
    localparam int unsigned CW = rte_pkg::DCNT_W;

    logic [QW-1:0]   r_sh;
    logic [VW-2:0]   r_rem, r_d;
    logic            r_neg, r_busy;
    logic [CW-1:0]   r_cnt;
    logic [VW-1:0]   num_mag, rem2;
    logic            fit;
    logic [QW:0]     q1;

    assign num_mag = i_num[VW-1] ? VW'(-i_num) : VW'(i_num);
    assign rem2    = {r_rem, r_sh[QW-1]};
    assign fit     = rem2 >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= {num_mag, {(QW-VW){1'b0}}};
            r_rem <= '0;
            r_d   <= i_den[VW-2:0];
            r_neg <= i_num[VW-1];
        end else if (r_busy && r_cnt != '0) begin
            r_sh  <= {r_sh[QW-2:0], fit};
            r_rem <= fit ? (VW-1)'(rem2 - {1'b0, r_d}) : rem2[VW-2:0];
        end
    end

    assign o_done = r_busy && r_cnt == '0;

    always_comb begin
        q1 = {1'b0, r_sh} + (QW+1)'({1'b0, r_rem} >= ({1'b0, r_d} - {1'b0, r_rem}));
        if (r_neg) begin
            o_ovf = q1 > (QW+1)'({1'b1, {(VW-1){1'b0}}});
            o_res = o_ovf ? {1'b1, {(VW-1){1'b0}}} : VW'(-q1[VW-1:0]);
        end else begin
            o_ovf = q1 > (QW+1)'({1'b0, {(VW-1){1'b1}}});
            o_res = o_ovf ? {1'b0, {(VW-1){1'b1}}} : q1[VW-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rte_dp.sv =====
// ----------------------------------------------------------------------------
// rte_dp
// Datapath: configuration, estimator state, operand selection, the
// multiply-accumulate unit, the divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire rte_pkg::t_cmd                      i_cmd,
    output rte_pkg::t_sts                           o_sts,
    input  wire rte_pkg::t_in_item                  i_in,
    input  wire logic                               i_cfg_we,
    input  wire logic [rte_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rte_pkg::COV_W-1:0]          i_cfg_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output rte_pkg::t_out_item                      o_out
);

    localparam int unsigned VW = rte_pkg::VAL_W;
    localparam int unsigned SW = rte_pkg::SMP_W;

    logic                 r_mode;
    logic signed [SW-1:0] r_df, r_gf, r_ds, r_gsc, r_gsv;
    logic [rte_pkg::COV_W-1:0] r_icov;

    logic signed [SW-1:0] r_v, r_i, r_y, r_pv, r_pi;
    logic signed [VW-1:0] r_phi0, r_phi1, r_c0, r_c1, r_c2, r_c3;
    logic signed [VW-1:0] r_t0, r_t1, r_den, r_g0, r_g1, r_par0, r_par1, r_pred, r_err;
    logic                 r_clip;

    logic signed [SW:0]   sum_v, sum_i, dif_i;
    logic signed [VW-1:0] diff_v, diff_i_add, diff_i_sub;
    logic signed [VW-1:0] op_a, op_b, wr_val, icov_v;
    logic                 wr_en, mac_done, mac_ovf, div_done, div_ovf;
    logic signed [VW-1:0] mac_res, div_res;

    function automatic logic signed [VW-1:0] sx(input logic signed [SW-1:0] x);
        return VW'(x);
    endfunction

    function automatic logic signed [VW-1:0] d12(input logic signed [SW:0] x);
        return {{(VW-SW-13){x[SW]}}, x, 12'b0};
    endfunction

    assign sum_v      = {r_v[SW-1], r_v} + {r_pv[SW-1], r_pv};
    assign sum_i      = {r_i[SW-1], r_i} + {r_pi[SW-1], r_pi};
    assign dif_i      = {r_i[SW-1], r_i} - {r_pi[SW-1], r_pi};
    assign diff_v     = d12(sum_v);
    assign diff_i_add = d12(sum_i);
    assign diff_i_sub = d12(dif_i);
    assign icov_v     = {1'b0, r_icov};

    function automatic logic signed [VW-1:0] opsel(input rte_pkg::t_opd c);
        logic signed [VW-1:0] v;
        case (c)
            rte_pkg::OPD_PHI0:  v = r_phi0;
            rte_pkg::OPD_PHI1:  v = r_phi1;
            rte_pkg::OPD_C0:    v = r_c0;
            rte_pkg::OPD_C1:    v = r_c1;
            rte_pkg::OPD_C2:    v = r_c2;
            rte_pkg::OPD_C3:    v = r_c3;
            rte_pkg::OPD_T0:    v = r_t0;
            rte_pkg::OPD_T1:    v = r_t1;
            rte_pkg::OPD_DEN:   v = r_den;
            rte_pkg::OPD_G0:    v = r_g0;
            rte_pkg::OPD_G1:    v = r_g1;
            rte_pkg::OPD_PAR0:  v = r_par0;
            rte_pkg::OPD_PAR1:  v = r_par1;
            rte_pkg::OPD_PRED:  v = r_pred;
            rte_pkg::OPD_ERR:   v = r_err;
            rte_pkg::OPD_ONE:   v = VW'(1) << 28;
            rte_pkg::OPD_UNIT:  v = VW'(1);
            rte_pkg::OPD_Y12:   v = {{(VW-SW-12){r_y[SW-1]}}, r_y, 12'b0};
            rte_pkg::OPD_DECAY: v = (r_mode == rte_pkg::MODE_FIRST) ? sx(r_df) : sx(r_ds);
            rte_pkg::OPD_GAIN0: v = (r_mode == rte_pkg::MODE_FIRST) ? sx(r_gf) : sx(r_gsc);
            rte_pkg::OPD_GAIN1: v = (r_mode == rte_pkg::MODE_FIRST) ? sx(r_gf) : sx(r_gsv);
            rte_pkg::OPD_DIFF0: v = (r_mode == rte_pkg::MODE_FIRST) ? diff_v : diff_i_sub;
            rte_pkg::OPD_DIFF1: v = (r_mode == rte_pkg::MODE_FIRST) ? diff_i_add : diff_v;
            default:            v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        op_a = opsel(i_cmd.uop.a);
        op_b = opsel(i_cmd.uop.b);
    end

    rte_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mac_start),
        .i_clear (i_cmd.mac_clear),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_neg   (i_cmd.uop.neg),
        .i_sh    (i_cmd.uop.sh),
        .o_done  (mac_done),
        .o_res   (mac_res),
        .o_ovf   (mac_ovf)
    );

    rte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (op_a),
        .i_den   (op_b),
        .o_done  (div_done),
        .o_res   (div_res),
        .o_ovf   (div_ovf)
    );

    assign wr_en  = i_cmd.fin_write || i_cmd.div_write || i_cmd.zero_write;
    assign wr_val = i_cmd.fin_write ? mac_res : (i_cmd.div_write ? div_res : '0);

    assign o_sts.mac_done = mac_done;
    assign o_sts.div_done = div_done;
    assign o_sts.den_pos  = !r_den[VW-1] && (r_den != '0);
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rte_pkg::MODE_FIRST;
            r_df   <= '0;
            r_gf   <= '0;
            r_ds   <= '0;
            r_gsc  <= '0;
            r_gsv  <= '0;
            r_icov <= rte_pkg::INIT_COV_RST;
        end else if (i_cfg_we) begin
            case (rte_pkg::t_cfg_idx'(i_cfg_idx))
                rte_pkg::CFG_MODE:             r_mode <= i_cfg_data[0];
                rte_pkg::CFG_DECAY_FIRST:      r_df   <= i_cfg_data[SW-1:0];
                rte_pkg::CFG_GAIN_FIRST:       r_gf   <= i_cfg_data[SW-1:0];
                rte_pkg::CFG_DECAY_SECOND:     r_ds   <= i_cfg_data[SW-1:0];
                rte_pkg::CFG_GAIN_SECOND_CUR:  r_gsc  <= i_cfg_data[SW-1:0];
                rte_pkg::CFG_GAIN_SECOND_VOLT: r_gsv  <= i_cfg_data[SW-1:0];
                rte_pkg::CFG_INIT_COV:         r_icov <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sample capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v <= i_in.voltage_sample;
            r_i <= i_in.current_sample;
            r_y <= i_in.measured_output;
        end
    end

    // estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_pv   <= '0;
            r_pi   <= '0;
            r_phi0 <= '0;
            r_phi1 <= '0;
            r_par0 <= '0;
            r_par1 <= '0;
            r_pred <= '0;
            r_c0   <= icov_v;
            r_c1   <= '0;
            r_c2   <= '0;
            r_c3   <= icov_v;
            r_clip <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_clip <= 1'b0;
            end else if ((i_cmd.fin_write && mac_ovf) || (i_cmd.div_write && div_ovf)
                         || i_cmd.zero_write) begin
                r_clip <= 1'b1;
            end
            if (i_cmd.fin_write && i_cmd.uop.dst == rte_pkg::OPD_PHI1) begin
                r_pv <= r_v;
                r_pi <= r_i;
            end
            if (wr_en) begin
                case (i_cmd.uop.dst)
                    rte_pkg::OPD_PHI0: r_phi0 <= wr_val;
                    rte_pkg::OPD_PHI1: r_phi1 <= wr_val;
                    rte_pkg::OPD_C0:   r_c0   <= wr_val;
                    rte_pkg::OPD_C1:   r_c1   <= wr_val;
                    rte_pkg::OPD_C2:   r_c2   <= wr_val;
                    rte_pkg::OPD_C3:   r_c3   <= wr_val;
                    rte_pkg::OPD_PAR0: r_par0 <= wr_val;
                    rte_pkg::OPD_PAR1: r_par1 <= wr_val;
                    rte_pkg::OPD_PRED: r_pred <= wr_val;
                    default: ;
                endcase
            end
        end
    end

    // scratch values
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            case (i_cmd.uop.dst)
                rte_pkg::OPD_T0:  r_t0  <= wr_val;
                rte_pkg::OPD_T1:  r_t1  <= wr_val;
                rte_pkg::OPD_DEN: r_den <= wr_val;
                rte_pkg::OPD_G0:  r_g0  <= wr_val;
                rte_pkg::OPD_G1:  r_g1  <= wr_val;
                rte_pkg::OPD_ERR: r_err <= wr_val;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_write) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_write) begin
            o_out.predicted_output <= r_pred;
            o_out.param_first      <= r_par0;
            o_out.param_second     <= r_par1;
            o_out.saturated        <= r_clip;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rte_ctrl.sv =====
// ----------------------------------------------------------------------------
// rte_ctrl
// Sequencer: walks the step program and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_restart,
    output logic               o_in_ready,
    input  wire rte_pkg::t_sts i_sts,
    output rte_pkg::t_cmd      o_cmd
);

    localparam int unsigned PW = rte_pkg::PC_W;

    rte_pkg::t_state r_state, n_state;
    logic [PW-1:0]   r_pc, n_pc;
    rte_pkg::t_uop   uop;
    logic            at_last;

    assign uop     = rte_pkg::prog(r_pc);
    assign at_last = r_pc == rte_pkg::PC_LAST;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rte_pkg::S_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            rte_pkg::S_IDLE: begin
                if (i_start) begin
                    n_pc    = '0;
                    n_state = i_restart ? rte_pkg::S_OUT : rte_pkg::S_EXEC;
                end
            end
            rte_pkg::S_EXEC: begin
                if (uop.kind == rte_pkg::K_MAC) begin
                    n_state = rte_pkg::S_MAC_WAIT;
                end else if (i_sts.den_pos) begin
                    n_state = rte_pkg::S_DIV_WAIT;
                end else begin
                    n_pc    = r_pc + PW'(1);
                    n_state = at_last ? rte_pkg::S_OUT : rte_pkg::S_EXEC;
                end
            end
            rte_pkg::S_MAC_WAIT: begin
                if (i_sts.mac_done) begin
                    if (uop.last) begin
                        n_state = rte_pkg::S_FIN;
                    end else begin
                        n_pc    = r_pc + PW'(1);
                        n_state = rte_pkg::S_EXEC;
                    end
                end
            end
            rte_pkg::S_FIN: begin
                n_pc    = r_pc + PW'(1);
                n_state = at_last ? rte_pkg::S_OUT : rte_pkg::S_EXEC;
            end
            rte_pkg::S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_pc    = r_pc + PW'(1);
                    n_state = at_last ? rte_pkg::S_OUT : rte_pkg::S_EXEC;
                end
            end
            rte_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = rte_pkg::S_IDLE;
                end
            end
            default: n_state = rte_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.uop        = uop;
        case (r_state)
            rte_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load      = i_start;
                o_cmd.mac_clear = i_start;
                o_cmd.restart   = i_start && i_restart;
            end
            rte_pkg::S_EXEC: begin
                if (uop.kind == rte_pkg::K_MAC) begin
                    o_cmd.mac_start = 1'b1;
                end else if (i_sts.den_pos) begin
                    o_cmd.div_start = 1'b1;
                end else begin
                    o_cmd.zero_write = 1'b1;
                end
            end
            rte_pkg::S_FIN: begin
                o_cmd.fin_write = 1'b1;
                o_cmd.mac_clear = 1'b1;
            end
            rte_pkg::S_DIV_WAIT: begin
                o_cmd.div_write = i_sts.div_done;
            end
            rte_pkg::S_OUT: begin
                o_cmd.out_write = i_sts.out_free;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/rls_two_param_estimator_unit.sv =====
// ----------------------------------------------------------------------------
// rls_two_param_estimator_unit
// Two-parameter recursive least squares estimator, fixed point.
// ----------------------------------------------------------------------------
// One item is worked at a time. A sample item runs 31 multiply-accumulate
// terms on a single 28x28 multiplier (four partial products per 56x56 term),
// fifteen rounding writes, and two gain divisions on a radix-2 divider (84
// quotient bits). A restart item resets the estimator state and skips the
// step program. The next item is taken while the previous result waits in
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_two_param_estimator_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire rte_pkg::t_in_item                 i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output rte_pkg::t_out_item                     o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [rte_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rte_pkg::COV_W-1:0]         i_cfg_data
);

    rte_pkg::t_cmd cmd;
    rte_pkg::t_sts sts;
    logic          start;

    assign start = i_in_valid && o_in_ready;

    rte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_restart  (i_in.req_type == rte_pkg::REQ_RESTART),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rte_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rte_checker.sv =====
// ----------------------------------------------------------------------------
// rte_checker
// Port-level checks of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire rte_pkg::t_out_item o_out
);

    // result register empties on reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // a new result is loaded only while no input is being taken
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared from idle");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

endmodule

bind rls_two_param_estimator_unit rte_checker u_rte_checker (.*);

`default_nettype wire
